// File: hw/rtl/pdr_pkg.sv
// Package for the packet dedup repeater: field widths, command and verdict codes,
// configuration register indexes, payload structs and controller/datapath links.
// No dependencies.
package pdr_pkg;

  localparam int ADDR_W  = 48;
  localparam int SEQ_W   = 16;
  localparam int LEN_W   = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int SEL_W   = 4;
  localparam int KNOWN_W = 5;
  localparam int TTL_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [1:0] FUNC_PKT  = 2'd0;
  localparam logic [1:0] FUNC_CLR  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [1:0] VERD_FWD      = 2'd0;
  localparam logic [1:0] VERD_DISABLED = 2'd1;
  localparam logic [1:0] VERD_SHORT    = 2'd2;
  localparam logic [1:0] VERD_DUP      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL     = 2'd2;

  localparam logic [TTL_W-1:0] TTL_RESET = 16'd5000;
  localparam logic [LEN_W-1:0] MIN_LEN   = 8'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] src_addr;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  length;
    logic [TIME_W-1:0] now_ms;
    logic [SEL_W-1:0]  client_sel;
  } in_item_t;

  typedef struct packed {
    logic               forward;
    logic [1:0]         verdict;
    logic [CNT_W-1:0]   forwarded_total;
    logic [KNOWN_W-1:0] clients_known;
    logic [ADDR_W-1:0]  client_addr;
    logic [CNT_W-1:0]   client_packets;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       scan_go;
    logic       commit;
    logic       cl_go;
    logic       cl_add;
    logic       clr_go;
    logic       stat_clr;
    logic       rd_issue;
    logic       rd_take;
    logic       set_res;
    logic [1:0] verdict;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       disabled;
    logic       too_short;
    logic       is_gateway;
    logic       fill_zero;
    logic       scan_hit;
    logic       scan_end;
    logic       cl_hit;
    logic       cl_end;
    logic       clr_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/packet_dedup_repeater_unit.sv
// Top level of the packet dedup repeater: controller plus datapath.
// Depends on pdr_pkg, pdr_ctrl and pdr_dp.
//
// Usage: present a command on in_item and raise start while busy is low; the
// transaction is taken at that edge and busy rises. Function 0 judges a received
// packet (enable, length, dedup cache lookup), function 1 clears the statistics,
// function 2 reads one client table entry, function 3 does nothing.
// The single result appears on out_item for one cycle with out_valid high; the
// receiver cannot stall, and busy drops in the cycle after the strobe.
// Rejected packets, a clear with an empty table and function 3 end without a walk;
// a read passes an issue and a take state; a duplicate ends the cache walk at its
// hit; a forwarded packet walks the whole cache and then, unless it comes from the
// gateway or the table is empty, the client table; a statistics clear walks the
// known clients. Each walk goes one entry per cycle through the registered read
// ports of the cache and client table. Configuration (cfg_we, cfg_idx, cfg_wdata)
// is to be written by the user only while busy is low; the block does not enforce it.
// Reset clears the cache valid bits, ring pointer, counters and client count and
// loads enable 0, gateway 0 and a 5000 ms lifetime.
module packet_dedup_repeater_unit #(
  parameter int CACHE_DEPTH  = 10,
  parameter int CLIENT_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pdr_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output pdr_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pdr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pdr_dp #(
    .CACHE_DEPTH  (CACHE_DEPTH),
    .CLIENT_DEPTH (CLIENT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTH
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a transaction");

  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block did not return to idle after its result");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted transaction did not raise busy");

  a_fwd_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.forward |-> out_item.verdict == VERD_FWD)
    else $error("forward flag disagrees with verdict");
`endif

endmodule

// File: hw/rtl/pdr_ctrl.sv
// Controller state machine of the packet dedup repeater.
// Depends on pdr_pkg for the command/status structs and the function/verdict codes.
module pdr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output pdr_pkg::dp_cmd_t  cmd,
  input  pdr_pkg::dp_sts_t  sts
);
  import pdr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_COMMIT   = 4'd3;
  localparam logic [3:0] S_CLIENT   = 4'd4;
  localparam logic [3:0] S_CL_ADD   = 4'd5;
  localparam logic [3:0] S_CLR      = 4'd6;
  localparam logic [3:0] S_RD_ISSUE = 4'd7;
  localparam logic [3:0] S_RD_TAKE  = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.idx_clr = 1'b1;
        case (sts.func)
          FUNC_PKT: begin
            if (sts.disabled) begin
              cmd.set_res = 1'b1;
              cmd.verdict = VERD_DISABLED;
              state_nxt   = S_DONE;
            end else if (sts.too_short) begin
              cmd.set_res = 1'b1;
              cmd.verdict = VERD_SHORT;
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          FUNC_CLR: begin
            cmd.stat_clr = 1'b1;
            state_nxt    = sts.fill_zero ? S_DONE : S_CLR;
          end
          FUNC_READ: state_nxt = S_RD_ISSUE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_go = 1'b1;
        if (sts.scan_hit) begin
          cmd.set_res = 1'b1;
          cmd.verdict = VERD_DUP;
          state_nxt   = S_DONE;
        end else if (sts.scan_end) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit  = 1'b1;
        cmd.idx_clr = 1'b1;
        cmd.set_res = 1'b1;
        cmd.verdict = VERD_FWD;
        if (sts.is_gateway) begin
          state_nxt = S_DONE;
        end else if (sts.fill_zero) begin
          state_nxt = S_CL_ADD;
        end else begin
          state_nxt = S_CLIENT;
        end
      end
      S_CLIENT: begin
        cmd.cl_go = 1'b1;
        if (sts.cl_hit) begin
          state_nxt = S_DONE;
        end else if (sts.cl_end) begin
          state_nxt = S_CL_ADD;
        end
      end
      S_CL_ADD: begin
        cmd.cl_add = 1'b1;
        state_nxt  = S_DONE;
      end
      S_CLR: begin
        cmd.clr_go = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_TAKE;
      end
      S_RD_TAKE: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// File: hw/rtl/pdr_dp.sv
// Datapath of the packet dedup repeater: configuration registers, dedup cache,
// client table, counters and result registers. Depends on pdr_pkg.
module pdr_dp #(
  parameter int CACHE_DEPTH  = 10,
  parameter int CLIENT_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pdr_pkg::in_item_t                   in_item,
  output pdr_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  pdr_pkg::dp_cmd_t                    cmd,
  output pdr_pkg::dp_sts_t                    sts
);
  import pdr_pkg::*;

  localparam int CA_W   = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CI_W   = (CLIENT_DEPTH > 1) ? $clog2(CLIENT_DEPTH) : 1;
  localparam int FILL_W = $clog2(CLIENT_DEPTH + 1);
  localparam int CMP_W  = 8;
  localparam logic [CA_W-1:0]   CA_LAST  = CA_W'(CACHE_DEPTH - 1);
  localparam logic [CI_W-1:0]   CI_LAST  = CI_W'(CLIENT_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CLIENT_DEPTH);

  // configuration
  logic              enable_r;
  logic [ADDR_W-1:0] gw_addr_r;
  logic [TTL_W-1:0]  ttl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      gw_addr_r <= '0;
      ttl_r     <= TTL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENABLE:  enable_r  <= cfg_wdata[0];
        CFG_GATEWAY: gw_addr_r <= cfg_wdata[ADDR_W-1:0];
        CFG_TTL:     ttl_r     <= cfg_wdata[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  // latched transaction and result fields
  in_item_t          in_r;
  logic              fwd_r;
  logic [1:0]        verdict_r;
  logic [ADDR_W-1:0] caddr_r;
  logic [CNT_W-1:0]  cpk_r;
  logic [CNT_W-1:0]  fwd_cnt_r;
  logic [FILL_W-1:0] fill_r;
  logic [CA_W-1:0]   ptr_r;

  // cache storage and scan pipeline
  logic [ADDR_W-1:0]      ca_addr_mem [CACHE_DEPTH];
  logic [SEQ_W-1:0]       ca_seq_mem  [CACHE_DEPTH];
  logic [TIME_W-1:0]      ca_time_mem [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] ca_valid_r;
  logic [ADDR_W-1:0]      ca_rd_addr_r;
  logic [SEQ_W-1:0]       ca_rd_seq_r;
  logic [TIME_W-1:0]      ca_rd_time_r;
  logic [CA_W-1:0]        ca_idx_r;
  logic [CA_W-1:0]        ca_ridx_r;
  logic                   ca_rv_r;

  // client table and scan pipeline
  logic [ADDR_W-1:0] cl_mac_mem [CLIENT_DEPTH];
  logic [CNT_W-1:0]  cl_cnt_mem [CLIENT_DEPTH];
  logic [ADDR_W-1:0] cl_rd_mac_r;
  logic [CNT_W-1:0]  cl_rd_cnt_r;
  logic [CI_W-1:0]   cl_idx_r;
  logic [CI_W-1:0]   cl_ridx_r;
  logic              cl_rv_r;

  logic              ca_eval, ca_live, ca_expired, ca_match, ca_hit, ca_drop;
  logic [TIME_W-1:0] ca_age;
  logic              cl_eval, cl_in, cl_hit, cl_full, sel_ok;
  logic [CI_W-1:0]   cl_raddr;
  logic              cl_we, cl_mac_we;
  logic [CI_W-1:0]   cl_waddr;
  logic [CNT_W-1:0]  cl_wcnt;

  // cache entry compare: age in modulo-2^32 time, equal age still alive
  assign ca_eval    = cmd.scan_go && ca_rv_r;
  assign ca_live    = ca_valid_r[ca_ridx_r];
  assign ca_age     = in_r.now_ms - ca_rd_time_r;
  assign ca_expired = ca_age > TIME_W'(ttl_r);
  assign ca_match   = (ca_rd_addr_r == in_r.src_addr) && (ca_rd_seq_r == in_r.seq);
  assign ca_hit     = ca_eval && ca_live && !ca_expired && ca_match;
  assign ca_drop    = ca_eval && ca_live && ca_expired;

  assign cl_eval  = cmd.cl_go && cl_rv_r;
  assign cl_in    = FILL_W'(cl_ridx_r) < fill_r;
  assign cl_hit   = cl_eval && cl_in && (cl_rd_mac_r == in_r.src_addr);
  assign cl_full  = (fill_r == FILL_MAX);
  assign sel_ok   = CMP_W'(in_r.client_sel) < CMP_W'(fill_r);
  assign cl_raddr = cmd.rd_issue ? CI_W'(in_r.client_sel) : cl_idx_r;

  // single write port of the client table
  always_comb begin
    cl_we     = 1'b0;
    cl_mac_we = 1'b0;
    cl_waddr  = cl_idx_r;
    cl_wcnt   = '0;
    if (cl_hit) begin
      cl_we    = 1'b1;
      cl_waddr = cl_ridx_r;
      cl_wcnt  = cl_rd_cnt_r + 1'b1;
    end else if (cmd.cl_add && !cl_full) begin
      cl_we     = 1'b1;
      cl_mac_we = 1'b1;
      cl_waddr  = fill_r[CI_W-1:0];
      cl_wcnt   = CNT_W'(1);
    end else if (cmd.clr_go) begin
      cl_we    = 1'b1;
      cl_waddr = cl_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ca_addr_mem[ptr_r] <= in_r.src_addr;
      ca_seq_mem[ptr_r]  <= in_r.seq;
      ca_time_mem[ptr_r] <= in_r.now_ms;
    end
    ca_rd_addr_r <= ca_addr_mem[ca_idx_r];
    ca_rd_seq_r  <= ca_seq_mem[ca_idx_r];
    ca_rd_time_r <= ca_time_mem[ca_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cl_we) begin
      cl_cnt_mem[cl_waddr] <= cl_wcnt;
    end
    if (cl_mac_we) begin
      cl_mac_mem[cl_waddr] <= in_r.src_addr;
    end
    cl_rd_mac_r <= cl_mac_mem[cl_raddr];
    cl_rd_cnt_r <= cl_cnt_mem[cl_raddr];
  end

  // scan index counters and read-valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_idx_r  <= '0;
      ca_ridx_r <= '0;
      ca_rv_r   <= 1'b0;
      cl_idx_r  <= '0;
      cl_ridx_r <= '0;
      cl_rv_r   <= 1'b0;
    end else if (cmd.idx_clr) begin
      ca_idx_r <= '0;
      ca_rv_r  <= 1'b0;
      cl_idx_r <= '0;
      cl_rv_r  <= 1'b0;
    end else begin
      ca_rv_r   <= cmd.scan_go;
      ca_ridx_r <= ca_idx_r;
      if (cmd.scan_go && (ca_idx_r != CA_LAST)) begin
        ca_idx_r <= ca_idx_r + 1'b1;
      end
      cl_rv_r   <= cmd.cl_go;
      cl_ridx_r <= cl_idx_r;
      if ((cmd.cl_go || cmd.clr_go) && (cl_idx_r != CI_LAST)) begin
        cl_idx_r <= cl_idx_r + 1'b1;
      end
    end
  end

  // control state: valid bits, ring pointer, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_valid_r <= '0;
      ptr_r      <= '0;
      fwd_cnt_r  <= '0;
      fill_r     <= '0;
    end else begin
      if (ca_drop) begin
        ca_valid_r[ca_ridx_r] <= 1'b0;
      end
      if (cmd.commit) begin
        ca_valid_r[ptr_r] <= 1'b1;
        ptr_r             <= (ptr_r == CA_LAST) ? '0 : ptr_r + 1'b1;
        fwd_cnt_r         <= fwd_cnt_r + 1'b1;
      end else if (cmd.stat_clr) begin
        fwd_cnt_r <= '0;
      end
      if (cmd.cl_add && !cl_full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // transaction and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r      <= in_item;
      fwd_r     <= 1'b0;
      verdict_r <= '0;
      caddr_r   <= '0;
      cpk_r     <= '0;
    end else begin
      if (cmd.set_res) begin
        fwd_r     <= (cmd.verdict == VERD_FWD);
        verdict_r <= cmd.verdict;
      end
      if (cmd.rd_take && sel_ok) begin
        caddr_r <= cl_rd_mac_r;
        cpk_r   <= cl_rd_cnt_r;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.func       = in_r.func;
    sts.disabled   = !enable_r;
    sts.too_short  = in_r.length < MIN_LEN;
    sts.is_gateway = (in_r.src_addr == gw_addr_r);
    sts.fill_zero  = (fill_r == '0);
    sts.scan_hit   = ca_hit;
    sts.scan_end   = ca_eval && (ca_ridx_r == CA_LAST) && !ca_hit;
    sts.cl_hit     = cl_hit;
    sts.cl_end     = cl_eval && (FILL_W'(cl_ridx_r) == fill_r - 1'b1) && !cl_hit;
    sts.clr_last   = (FILL_W'(cl_idx_r) == fill_r - 1'b1);
  end

  always_comb begin
    out_item                 = '0;
    out_item.forward         = fwd_r;
    out_item.verdict         = verdict_r;
    out_item.forwarded_total = fwd_cnt_r;
    out_item.clients_known   = KNOWN_W'(fill_r);
    out_item.client_addr     = caddr_r;
    out_item.client_packets  = cpk_r;
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for packet_dedup_repeater_unit: directed corner cases, then random command
// streams, each result checked against an in-bench model of the dedup cache and client table.
// Depends on pdr_pkg and the packet_dedup_repeater_unit RTL.
module tb_top;
  import pdr_pkg::*;

  localparam int CACHE_N     = 10;
  localparam int CLIENT_N    = 16;
  localparam int POOL_N      = 24;
  localparam int HIST_N      = 12;
  localparam int SETTLE      = 3;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t             kind;
    in_item_t              cmd;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    calm;
  } pending_act_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  packet_dedup_repeater_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Repeater model: configuration copy, dedup ring and client table
  logic              rep_enable = 1'b0;
  logic [ADDR_W-1:0] gw_mac     = '0;
  logic [TTL_W-1:0]  life_ms    = TTL_RESET;
  logic [ADDR_W-1:0] seen_addr  [CACHE_N];
  logic [SEQ_W-1:0]  seen_seq   [CACHE_N];
  logic [TIME_W-1:0] seen_stamp [CACHE_N];
  bit                seen_live  [CACHE_N];
  int                ring_wr    = 0;
  logic [ADDR_W-1:0] peer_mac   [CLIENT_N];
  logic [CNT_W-1:0]  peer_hits  [CLIENT_N];
  int                peer_count = 0;
  logic [CNT_W-1:0]  fwd_count  = '0;

  pending_act_t      act_q[$];
  out_item_t         repeater_results[$];
  int                accepted_cnt = 0;
  int                strobe_cnt   = 0;
  int                quiet_cycles = 0;
  int                mismatch_cnt = 0;
  int                cycle_cnt    = 0;

  logic [ADDR_W-1:0] mac_pool  [POOL_N];
  logic [ADDR_W-1:0] hist_addr [HIST_N];
  logic [SEQ_W-1:0]  hist_seq  [HIST_N];
  int                hist_fill = 0;
  int                hist_wr   = 0;
  logic [TIME_W-1:0] clock_ms  = '0;

  function automatic out_item_t predict_repeater(in_item_t cmd);
    out_item_t         res;
    logic [TIME_W-1:0] age;
    bit                hit;
    bit                known;
    int                i;
    res   = '0;
    hit   = 1'b0;
    known = 1'b0;
    case (cmd.func)
      FUNC_PKT: begin
        if (!rep_enable) begin
          res.verdict = VERD_DISABLED;
        end else if (cmd.length < MIN_LEN) begin
          res.verdict = VERD_SHORT;
        end else begin
          // stop at the first live match; entries past it keep their valid bit
          for (i = 0; i < CACHE_N && !hit; i++) begin
            if (seen_live[i]) begin
              age = cmd.now_ms - seen_stamp[i];
              if (age > life_ms)
                seen_live[i] = 1'b0;
              else if (seen_addr[i] == cmd.src_addr && seen_seq[i] == cmd.seq)
                hit = 1'b1;
            end
          end
          if (hit) begin
            res.verdict = VERD_DUP;
          end else begin
            seen_addr[ring_wr]  = cmd.src_addr;
            seen_seq[ring_wr]   = cmd.seq;
            seen_stamp[ring_wr] = cmd.now_ms;
            seen_live[ring_wr]  = 1'b1;
            ring_wr = (ring_wr + 1 == CACHE_N) ? 0 : ring_wr + 1;
            if (cmd.src_addr != gw_mac) begin
              for (i = 0; i < peer_count && !known; i++) begin
                if (peer_mac[i] == cmd.src_addr) begin
                  peer_hits[i] = peer_hits[i] + 1'b1;
                  known        = 1'b1;
                end
              end
              // a full table drops new clients, the packet still goes out
              if (!known && peer_count < CLIENT_N) begin
                peer_mac[peer_count]  = cmd.src_addr;
                peer_hits[peer_count] = 1;
                peer_count++;
              end
            end
            fwd_count   = fwd_count + 1'b1;
            res.forward = 1'b1;
            res.verdict = VERD_FWD;
          end
        end
      end
      FUNC_CLR: begin
        fwd_count = '0;
        for (i = 0; i < peer_count; i++)
          peer_hits[i] = '0;
      end
      FUNC_READ: if (cmd.client_sel < peer_count) begin
        res.client_addr    = peer_mac[cmd.client_sel];
        res.client_packets = peer_hits[cmd.client_sel];
      end
      default: ;
    endcase
    res.forwarded_total = fwd_count;
    res.clients_known   = KNOWN_W'(peer_count);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  task automatic push_cmd(logic [1:0] f, logic [ADDR_W-1:0] a, logic [SEQ_W-1:0] s,
                          logic [LEN_W-1:0] l, logic [TIME_W-1:0] t,
                          logic [SEL_W-1:0] sel, bit calm);
    pending_act_t act;
    act.kind           = ACT_ITEM;
    act.cmd.func       = f;
    act.cmd.src_addr   = a;
    act.cmd.seq        = s;
    act.cmd.length     = l;
    act.cmd.now_ms     = t;
    act.cmd.client_sel = sel;
    act.idx            = '0;
    act.data           = '0;
    act.calm           = calm;
    act_q.push_back(act);
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    pending_act_t act;
    act.kind = ACT_CFG;
    act.cmd  = '0;
    act.idx  = idx;
    act.data = data;
    act.calm = 1'b0;
    act_q.push_back(act);
  endtask

  task automatic push_drain();
    pending_act_t act;
    act.kind = ACT_DRAIN;
    act.cmd  = '0;
    act.idx  = '0;
    act.data = '0;
    act.calm = 1'b0;
    act_q.push_back(act);
  endtask

  // Mostly well-formed arrivals over a small address pool, with resends of recent
  // packets and a time base that moves in steps scaled to the lifetime.
  task automatic queue_random_phase(int n, int ttl_hint, int calm_lo, int calm_hi);
    logic [1:0]        f;
    logic [ADDR_W-1:0] a;
    logic [SEQ_W-1:0]  s;
    logic [LEN_W-1:0]  l;
    logic [TIME_W-1:0] t;
    int                roll;
    int                k;
    int                i;
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      a    = rand48();
      s    = SEQ_W'($urandom);
      l    = LEN_W'($urandom);
      t    = $urandom;
      if (roll < 80) begin
        f    = FUNC_PKT;
        roll = $urandom_range(99);
        if (roll < 35 && hist_fill > 0) begin
          k = $urandom_range(hist_fill - 1);
          a = hist_addr[k];
          s = hist_seq[k];
        end else if (roll < 93) begin
          a = mac_pool[$urandom_range(POOL_N - 1)];
          s = SEQ_W'($urandom_range(15));
        end
        if ($urandom_range(99) < 90)
          l = LEN_W'($urandom_range(255, 4));
        else
          l = LEN_W'($urandom_range(3));
        if ($urandom_range(99) < 3)
          clock_ms = $urandom;
        else
          clock_ms = clock_ms + $urandom_range(ttl_hint / 3 + 1);
        t = clock_ms;
        hist_addr[hist_wr] = a;
        hist_seq[hist_wr]  = s;
        hist_wr = (hist_wr + 1) % HIST_N;
        if (hist_fill < HIST_N)
          hist_fill++;
      end else if (roll < 87) begin
        f = FUNC_READ;
      end else if (roll < 95) begin
        f = FUNC_CLR;
      end else begin
        f = FUNC_NONE;
      end
      push_cmd(f, a, s, l, t, SEL_W'($urandom), i >= calm_lo && i < calm_hi);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (mismatch_cnt < 10)
        $display("tb: %s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Driver: at most one transaction or configuration write per free cycle
  always @(posedge clk) begin : drive_proc
    pending_act_t head;
    logic         hold;
    logic         we_nxt;
    if (!rst_n) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      hold   = start && busy;
      we_nxt = 1'b0;
      if (start && !busy) begin
        repeater_results.push_back(predict_repeater(in_item));
        accepted_cnt++;
      end
      if (start || busy || accepted_cnt != strobe_cnt)
        quiet_cycles = 0;
      else if (quiet_cycles < SETTLE)
        quiet_cycles++;
      if (!hold && act_q.size() != 0) begin
        head = act_q[0];
        case (head.kind)
          ACT_ITEM: if (head.calm || $urandom_range(99) >= 19) begin
            in_item <= head.cmd;
            hold = 1'b1;
            void'(act_q.pop_front());
          end
          ACT_CFG: if (quiet_cycles >= SETTLE) begin
            we_nxt = 1'b1;
            cfg_idx   <= head.idx;
            cfg_wdata <= head.data;
            case (head.idx)
              CFG_ENABLE:  rep_enable = head.data[0];
              CFG_GATEWAY: gw_mac     = head.data[ADDR_W-1:0];
              CFG_TTL:     life_ms    = head.data[TTL_W-1:0];
              default: ;
            endcase
            quiet_cycles = 0;
            void'(act_q.pop_front());
          end
          ACT_DRAIN: if (quiet_cycles >= SETTLE) begin
            void'(act_q.pop_front());
          end
        endcase
      end
      start  <= hold;
      cfg_we <= we_nxt;
    end
  end

  // Monitor: every strobe is a transaction the receiver must take
  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (rst_n && out_valid) begin
      if (repeater_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("tb: result with nothing expected: %h", out_item);
        mismatch_cnt++;
      end else begin
        want = repeater_results.pop_front();
        check_field("forward", want.forward, out_item.forward);
        check_field("verdict", want.verdict, out_item.verdict);
        check_field("forwarded_total", want.forwarded_total, out_item.forwarded_total);
        check_field("clients_known", want.clients_known, out_item.clients_known);
        check_field("client_addr", want.client_addr, out_item.client_addr);
        check_field("client_packets", want.client_packets, out_item.client_packets);
        strobe_cnt <= strobe_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin : limit_proc
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus_proc
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_x;
    logic [ADDR_W-1:0] addr_y;
    int                i;
    addr_a = '1;
    addr_b = 48'h1;
    addr_x = 48'h5555_5555_5555;
    addr_y = 48'hAAAA_AAAA_AAAA;
    for (i = 0; i < POOL_N; i++)
      mac_pool[i] = rand48();
    mac_pool[0] = '0;
    mac_pool[1] = '1;

    // reset state: disabled, empty table
    push_cmd(FUNC_PKT, addr_a, 16'd1, 8'd10, 32'd0, 4'd0, 1'b0);
    push_cmd(FUNC_NONE, rand48(), 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b0);
    push_cmd(FUNC_CLR, '0, '0, '0, '0, '0, 1'b0);
    push_cmd(FUNC_READ, '0, '0, '0, '0, 4'd0, 1'b0);
    push_cfg(CFG_ENABLE, '1);

    // length limit, time zero entry, age equal to the lifetime, expiry, time wrap
    push_cmd(FUNC_PKT, addr_a, 16'hFFFF, 8'd0, 32'd0, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_a, 16'hFFFF, 8'd3, 32'd0, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_a, 16'hFFFF, 8'd4, 32'd0, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_a, 16'hFFFF, 8'd255, 32'd5000, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_a, 16'hFFFF, 8'd4, 32'd5001, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_b, 16'd0, 8'd4, 32'hFFFF_FFF0, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_b, 16'd0, 8'd4, 32'd10, 4'd0, 1'b0);
    // gateway sender is forwarded but not tracked
    push_cmd(FUNC_PKT, '0, 16'd5, 8'd20, 32'd20, 4'd0, 1'b0);
    push_cmd(FUNC_READ, '0, '0, '0, '0, 4'd0, 1'b0);
    push_cmd(FUNC_READ, '0, '0, '0, '0, 4'd1, 1'b0);
    push_cmd(FUNC_READ, '0, '0, '0, '0, 4'd2, 1'b0);
    push_cmd(FUNC_READ, '0, '0, '0, '0, 4'd15, 1'b0);
    push_cmd(FUNC_CLR, rand48(), '1, '1, '1, '1, 1'b0);
    push_cmd(FUNC_READ, '0, '0, '0, '0, 4'd0, 1'b0);

    // earlier time stamp: its wrapped age expires the cached entry, then a longer lifetime
    push_cfg(CFG_TTL, (rand48() & ~48'hFFFF) | 48'd100);
    push_cmd(FUNC_PKT, addr_x, 16'h1234, 8'd6, 32'd1000, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_y, 16'h4321, 8'd6, 32'd900, 4'd0, 1'b0);
    push_cmd(FUNC_PKT, addr_x, 16'h1234, 8'd6, 32'd1050, 4'd0, 1'b0);
    push_cfg(CFG_TTL, 48'd1000);
    push_cmd(FUNC_PKT, addr_y, 16'h4321, 8'd6, 32'd1100, 4'd0, 1'b0);
    push_cmd(FUNC_NONE, rand48(), 16'h0, 8'h0, 32'h0, 4'h0, 1'b0);

    clock_ms = 32'd2000;
    push_cfg(CFG_GATEWAY, mac_pool[3]);
    push_cfg(CFG_TTL, (rand48() & ~48'hFFFF) | 48'd5000);
    queue_random_phase(500, 5000, 0, 0);

    push_cfg(CFG_GATEWAY, '0);
    push_cfg(CFG_TTL, 48'd0);
    queue_random_phase(200, 0, 0, 0);

    push_cfg(CFG_GATEWAY, '1);
    push_cfg(CFG_TTL, 48'hFFFF);
    queue_random_phase(200, 65535, 0, 0);
    push_drain();
    queue_random_phase(200, 65535, 0, 0);

    push_cfg(CFG_ENABLE, rand48() & ~48'h1);
    push_cfg(CFG_TTL, rand48());
    queue_random_phase(100, 1000, 0, 0);

    push_cfg(CFG_ENABLE, rand48() | 48'h1);
    push_cfg(CFG_GATEWAY, rand48());
    push_cfg(CFG_TTL, 48'($urandom_range(3000, 1)));
    queue_random_phase(800, 1500, 300, 550);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (act_q.size() != 0 || start || accepted_cnt != strobe_cnt)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (repeater_results.size() != 0) begin
      $display("tb: %0d results never arrived", repeater_results.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
